// ===== design/ffar_pkg.sv =====
// ----------------------------------------------------------------------------
// ffar_pkg
// Types and constants shared by the first-fit address range allocator.
// ----------------------------------------------------------------------------
package ffar_pkg;

   localparam int BASE_W  = 20;
   localparam int COUNT_W = 21;
   localparam int ADDR_W  = 32;
   localparam int STAT_W  = 3;

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_ZERO     = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_RANGE = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd4;

   // register indexes
   localparam logic CSR_WINDOW_BASE = 1'b0;
   localparam logic CSR_WINDOW_END  = 1'b1;

   localparam logic [BASE_W-1:0]  WINDOW_BASE_RESET = 20'd786432;
   localparam logic [COUNT_W-1:0] WINDOW_END_RESET  = 21'd851968;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] size_bytes;
      logic [ADDR_W-1:0] free_addr;
   } req_data_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ADDR_W-1:0] alloc_addr;
   } rsp_data_type;

   // one table entry as it moves along the chain
   typedef struct packed {
      logic [BASE_W-1:0]  base_page;
      logic [COUNT_W-1:0] page_count;
   } entry_type;

   // what the controller hands to the chain each cycle
   typedef struct packed {
      logic      shift;
      entry_type feed;
   } chain_ctrl_type;

endpackage

// ===== design/ffar_cell.sv =====
// ----------------------------------------------------------------------------
// ffar_cell
// One slot of the region table; loads its left neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module ffar_cell (
   input  logic               clock,
   input  logic               shift,
   input  ffar_pkg::entry_type entry_in,
   output ffar_pkg::entry_type entry_out
);

   ffar_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

// ===== design/ffar_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffar_ctrl
// Sequencer: scans the rotating table, inserts or removes one entry per pass.
// ----------------------------------------------------------------------------
module ffar_ctrl #(
   parameter int MAX_REGIONS = 64,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ffar_pkg::req_data_type    req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ffar_pkg::rsp_data_type    rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_index,
   input  logic [ffar_pkg::COUNT_W-1:0] csr_data,
   input  ffar_pkg::entry_type       head,
   input  ffar_pkg::entry_type       next,
   output ffar_pkg::chain_ctrl_type  chain
);

   localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
   localparam int IDX_W   = $clog2(MAX_REGIONS);
   localparam int PAGES_W = $clog2(((64'd1 << 32) - 1) / PAGE_BYTES + 2);
   localparam int SUM_W   = ((PAGES_W > 22) ? PAGES_W : 22) + 1;
   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_REGIONS - 1);
   localparam logic [CNT_W-1:0] FULL      = CNT_W'(MAX_REGIONS);

   typedef enum logic [5:0] {
      IDLE   = 6'b000001,
      SCAN   = 6'b000010,
      CHECK  = 6'b000100,
      INSERT = 6'b001000,
      FREE   = 6'b010000,
      REPLY  = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [IDX_W-1:0]               step_ff, step_in;
   logic [SUM_W-1:0]               cand_ff, cand_in;
   logic [PAGES_W-1:0]             pages_ff, pages_in;
   logic [PAGES_W-1:0]             addr_page_ff, addr_page_in;
   logic                           aligned_ff, aligned_in;
   logic                           done_ff, done_in;
   logic                           op_ff, op_in;
   logic [ffar_pkg::STAT_W-1:0]    status_ff, status_in;
   ffar_pkg::entry_type            hold_ff, hold_in;
   logic [ffar_pkg::BASE_W-1:0]    win_base_ff;
   logic [ffar_pkg::COUNT_W-1:0]   win_end_ff;
   logic                           rsp_valid_ff;
   ffar_pkg::rsp_data_type         rsp_data_ff;

   logic                           last_step;
   logic                           entry_valid;
   logic [SUM_W-1:0]               head_base;
   logic [SUM_W-1:0]               head_end;
   logic [SUM_W-1:0]               need_end;
   logic [SUM_W-1:0]               end_eff;
   logic [PAGES_W-1:0]             req_addr_page;
   logic                           free_outside;
   logic                           matched;
   logic                           reply_load;

   assign last_step    = (step_ff == LAST_STEP);
   assign entry_valid  = ({{(CNT_W - IDX_W){1'b0}}, step_ff} < count_ff);
   assign head_base    = SUM_W'(head.base_page);
   assign head_end     = head_base + SUM_W'(head.page_count);
   assign need_end     = cand_ff + SUM_W'(pages_ff);
   // window end is capped at the top of page space
   assign end_eff      = win_end_ff[ffar_pkg::COUNT_W-1] ? SUM_W'(1 << ffar_pkg::BASE_W)
                                                        : SUM_W'(win_end_ff);
   assign req_addr_page = PAGES_W'(req_data.free_addr / PAGE_BYTES);
   assign free_outside = (SUM_W'(req_addr_page) < SUM_W'(win_base_ff)) ||
                         (SUM_W'(req_addr_page) >= SUM_W'(win_end_ff));
   assign matched      = !done_ff && entry_valid && aligned_ff &&
                         (SUM_W'(addr_page_ff) == head_base);
   assign reply_load   = (state_ff == REPLY) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      cand_in      = cand_ff;
      pages_in     = pages_ff;
      addr_page_in = addr_page_ff;
      aligned_in   = aligned_ff;
      done_in      = done_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      hold_in      = hold_ff;
      chain.shift  = 1'b0;
      chain.feed   = head;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               op_in   = req_data.req_type;
               step_in = '0;
               done_in = 1'b0;
               if (req_data.req_type == ffar_pkg::REQ_ALLOC) begin
                  pages_in = PAGES_W'((33'(req_data.size_bytes) + 33'(PAGE_BYTES - 1))
                                      / PAGE_BYTES);
                  cand_in  = SUM_W'(win_base_ff);
                  if (req_data.size_bytes == '0) begin
                     status_in = ffar_pkg::ST_ZERO;
                     state_in  = REPLY;
                  end else begin
                     state_in = SCAN;
                  end
               end else begin
                  addr_page_in = req_addr_page;
                  aligned_in   = ((req_data.free_addr % PAGE_BYTES) == 0);
                  if (free_outside) begin
                     status_in = ffar_pkg::ST_IGNORED;
                     state_in  = REPLY;
                  end else begin
                     state_in = FREE;
                  end
               end
            end
         end
         SCAN: begin
            chain.shift = 1'b1;
            step_in     = step_ff + 1'b1;
            if (!done_ff) begin
               if (!entry_valid || (need_end <= head_base)) begin
                  done_in = 1'b1;
               end else if (head_end > cand_ff) begin
                  cand_in = head_end;
               end
            end
            if (last_step) begin
               state_in = CHECK;
            end
         end
         CHECK: begin
            step_in = '0;
            done_in = 1'b0;
            if (need_end > end_eff) begin
               status_in = ffar_pkg::ST_NO_RANGE;
               state_in  = REPLY;
            end else if (count_ff == FULL) begin
               status_in = ffar_pkg::ST_FULL;
               state_in  = REPLY;
            end else begin
               state_in = INSERT;
            end
         end
         INSERT: begin
            chain.shift = 1'b1;
            step_in     = step_ff + 1'b1;
            if (done_ff) begin
               chain.feed = hold_ff;
               hold_in    = head;
            end else if (!(entry_valid && (head_base < cand_ff))) begin
               chain.feed.base_page  = cand_ff[ffar_pkg::BASE_W-1:0];
               chain.feed.page_count = ffar_pkg::COUNT_W'(pages_ff);
               hold_in = head;
               done_in = 1'b1;
            end
            if (last_step) begin
               count_in  = count_ff + 1'b1;
               status_in = ffar_pkg::ST_OK;
               state_in  = REPLY;
            end
         end
         FREE: begin
            chain.shift = 1'b1;
            step_in     = step_ff + 1'b1;
            // from the matching slot on, every entry moves up by one
            if (done_ff || matched) begin
               chain.feed = next;
            end
            if (matched) begin
               done_in = 1'b1;
            end
            if (last_step) begin
               if (done_ff || matched) begin
                  count_in  = count_ff - 1'b1;
                  status_in = ffar_pkg::ST_OK;
               end else begin
                  status_in = ffar_pkg::ST_IGNORED;
               end
               state_in = REPLY;
            end
         end
         REPLY: begin
            if (reply_load) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         win_base_ff  <= ffar_pkg::WINDOW_BASE_RESET;
         win_end_ff   <= ffar_pkg::WINDOW_END_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (reply_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            if (csr_index == ffar_pkg::CSR_WINDOW_BASE) begin
               win_base_ff <= csr_data[ffar_pkg::BASE_W-1:0];
            end else begin
               win_end_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      cand_ff      <= cand_in;
      pages_ff     <= pages_in;
      addr_page_ff <= addr_page_in;
      aligned_ff   <= aligned_in;
      done_ff      <= done_in;
      op_ff        <= op_in;
      status_ff    <= status_in;
      hold_ff      <= hold_in;
      if (reply_load) begin
         rsp_data_ff.status <= status_ff;
         if ((status_ff == ffar_pkg::ST_OK) && (op_ff == ffar_pkg::REQ_ALLOC)) begin
            rsp_data_ff.alloc_addr <= ffar_pkg::ADDR_W'(cand_ff * PAGE_BYTES);
         end else begin
            rsp_data_ff.alloc_addr <= '0;
         end
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/first_fit_address_range_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_address_range_allocator
// First-fit allocator of page ranges inside a configurable virtual window.
// ----------------------------------------------------------------------------
// Requests arrive on req_ (allocate or free), one result per request leaves
// on rsp_ (status and allocated address). csr_ writes the window base and end
// registers and is always ready; write them only while no request is open.
// The region table is a ring of MAX_REGIONS cells that rotates once per pass
// past the sequencer. Allocate: a scan pass, a check step, an insert pass
// and a reply step; the check step goes straight to reply when no range
// fits or the table is full. Free: a free pass, then the reply step. Zero
// size and out-of-window frees go straight to the reply step.
// One request is worked on at a time; req_ready is high while idle.
// A finished result waits in the output register while the next request is
// taken; the sequencer holds in its reply step if that register is still
// full. Reset empties the table and loads the default window; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module first_fit_address_range_allocator #(
   parameter int MAX_REGIONS = 64,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  ffar_pkg::req_data_type       req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ffar_pkg::rsp_data_type       rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [ffar_pkg::COUNT_W-1:0] csr_data
);

   ffar_pkg::chain_ctrl_type chain;
   ffar_pkg::entry_type      cell_out [MAX_REGIONS];

   assign csr_ready = 1'b1;

   ffar_ctrl #(
      .MAX_REGIONS (MAX_REGIONS),
      .PAGE_BYTES  (PAGE_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .head      (cell_out[MAX_REGIONS-1]),
      .next      (cell_out[MAX_REGIONS-2]),
      .chain     (chain)
   );

   // entry k of the table sits in the cell at MAX_REGIONS-1-k between passes
   for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
      if (k == 0) begin : g_first
         ffar_cell u_cell (
            .clock     (clock),
            .shift     (chain.shift),
            .entry_in  (chain.feed),
            .entry_out (cell_out[k])
         );
      end else begin : g_rest
         ffar_cell u_cell (
            .clock     (clock),
            .shift     (chain.shift),
            .entry_in  (cell_out[k-1]),
            .entry_out (cell_out[k])
         );
      end
   end

endmodule

// ===== bench/first_fit_address_range_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_address_range_allocator_tb
// Drives allocate and free transactions through the allocator with random
// idling on both sides and window register changes between phases. Every
// response is checked against an in-bench model of the sorted region table.
// ----------------------------------------------------------------------------
module first_fit_address_range_allocator_tb;

   localparam int MAX_REGIONS = 64;
   localparam int PAGE_BYTES  = 4096;
   localparam int PAGE_SPACE  = 1048576;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ffar_pkg::req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ffar_pkg::rsp_data_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = ffar_pkg::CSR_WINDOW_BASE;
   logic [ffar_pkg::COUNT_W-1:0] csr_data = '0;

   first_fit_address_range_allocator #(
      .MAX_REGIONS(MAX_REGIONS),
      .PAGE_BYTES(PAGE_BYTES)
   ) u_dut (.*);

   always #2 clock = ~clock;

   // model of the region table
   logic [ffar_pkg::BASE_W-1:0]  mdl_base [MAX_REGIONS];
   logic [ffar_pkg::COUNT_W-1:0] mdl_pages [MAX_REGIONS];
   int                           mdl_count;
   logic [ffar_pkg::BASE_W-1:0]  win_base;
   logic [ffar_pkg::COUNT_W-1:0] win_end;

   ffar_pkg::rsp_data_type pending_rsp[$];
   int  error_count = 0;
   int  quiet_cycles = 0;
   bit  idle_enable = 1'b1;
   bit  rsp_hold = 1'b0;

   function automatic ffar_pkg::rsp_data_type predict_response(ffar_pkg::req_data_type r);
      ffar_pkg::rsp_data_type o;
      longint pages, cand, lim, rend, lo, hi;
      int pos;
      o = '0;
      if (r.req_type == ffar_pkg::REQ_ALLOC) begin
         if (r.size_bytes == 0) begin
            o.status = ffar_pkg::ST_ZERO;
            return o;
         end
         pages = (longint'(r.size_bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
         lim = (win_end < PAGE_SPACE) ? win_end : PAGE_SPACE;
         cand = win_base;
         for (int i = 0; i < mdl_count; i++) begin
            if (cand + pages <= mdl_base[i]) break;
            rend = longint'(mdl_base[i]) + mdl_pages[i];
            if (rend > cand) cand = rend;
         end
         if (cand + pages > lim) begin
            o.status = ffar_pkg::ST_NO_RANGE;
            return o;
         end
         if (mdl_count >= MAX_REGIONS) begin
            o.status = ffar_pkg::ST_FULL;
            return o;
         end
         pos = 0;
         while (pos < mdl_count && mdl_base[pos] < cand) pos++;
         for (int i = mdl_count; i > pos; i--) begin
            mdl_base[i]  = mdl_base[i-1];
            mdl_pages[i] = mdl_pages[i-1];
         end
         mdl_base[pos]  = cand[ffar_pkg::BASE_W-1:0];
         mdl_pages[pos] = pages[ffar_pkg::COUNT_W-1:0];
         mdl_count++;
         o.status = ffar_pkg::ST_OK;
         o.alloc_addr = 32'(cand * PAGE_BYTES);
      end else begin
         lo = longint'(win_base) * PAGE_BYTES;
         hi = longint'(win_end) * PAGE_BYTES;
         o.status = ffar_pkg::ST_IGNORED;
         if (r.free_addr < lo || r.free_addr >= hi) return o;
         for (int i = 0; i < mdl_count; i++) begin
            if (longint'(mdl_base[i]) * PAGE_BYTES == r.free_addr) begin
               for (int j = i; j + 1 < mdl_count; j++) begin
                  mdl_base[j]  = mdl_base[j+1];
                  mdl_pages[j] = mdl_pages[j+1];
               end
               mdl_count--;
               o.status = ffar_pkg::ST_OK;
               return o;
            end
         end
      end
      return o;
   endfunction

   // response checker and ready driver
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response status=%0d addr=%h",
                     $realtime, rsp_data.status, rsp_data.alloc_addr);
            error_count++;
         end else begin
            if (rsp_data.status !== pending_rsp[0].status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        pending_rsp[0].status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.alloc_addr !== pending_rsp[0].alloc_addr) begin
               $display("%0t: alloc_addr expected %h actual %h", $realtime,
                        pending_rsp[0].alloc_addr, rsp_data.alloc_addr);
               error_count++;
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= !rsp_hold && (!idle_enable || $urandom_range(99) >= 37);

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("first_fit_address_range_allocator verification failed");
         $finish;
      end
   end

   task automatic write_window(logic idx, logic [ffar_pkg::COUNT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == ffar_pkg::CSR_WINDOW_BASE) win_base = value[ffar_pkg::BASE_W-1:0];
      else win_end = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_responses();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * MAX_REGIONS + 8) @(posedge clock);
   endtask

   // one request; checks a typed-in response when has_fixed is set
   task automatic send_request(ffar_pkg::req_data_type r, bit has_fixed = 0,
                               ffar_pkg::rsp_data_type fixed = '0);
      ffar_pkg::rsp_data_type exp_rsp;
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < 37) @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      exp_rsp = predict_response(r);
      if (has_fixed && exp_rsp !== fixed) begin
         $display("%0t: typed response %h disagrees with prediction %h",
                  $realtime, fixed, exp_rsp);
         error_count++;
      end
      pending_rsp.push_back(exp_rsp);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic ffar_pkg::req_data_type make_alloc(logic [31:0] sz);
      ffar_pkg::req_data_type r;
      r = '0;
      r.req_type = ffar_pkg::REQ_ALLOC;
      r.size_bytes = sz;
      r.free_addr = $urandom;
      return r;
   endfunction

   function automatic ffar_pkg::req_data_type make_free(logic [31:0] a);
      ffar_pkg::req_data_type r;
      r = '0;
      r.req_type = ffar_pkg::REQ_FREE;
      r.free_addr = a;
      r.size_bytes = $urandom;
      return r;
   endfunction

   // allocated page address, or a noisy one: fully random or offset from the window base
   function automatic logic [31:0] pick_free_addr();
      if (mdl_count > 0 && $urandom_range(99) < 80)
         return 32'(longint'(mdl_base[$urandom_range(mdl_count-1)]) * PAGE_BYTES);
      if ($urandom_range(1)) return $urandom;
      return 32'(longint'(win_base) * PAGE_BYTES + $urandom_range(1 << 20));
   endfunction

   typedef struct {
      ffar_pkg::req_data_type req;
      bit                     has_fixed;
      ffar_pkg::rsp_data_type fixed;
   } stim_row_type;

   stim_row_type directed_rows[$];

   initial begin
      stim_row_type           row;
      ffar_pkg::rsp_data_type rsp_tmp;
      logic [31:0]            sz;
      int                     win_choice;
      win_base = ffar_pkg::WINDOW_BASE_RESET;
      win_end  = ffar_pkg::WINDOW_END_RESET;
      mdl_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      rsp_tmp = '0;
      row.has_fixed = 1;
      rsp_tmp.status = ffar_pkg::ST_ZERO;
      row.req = make_alloc(32'd0); row.fixed = rsp_tmp; directed_rows.push_back(row);
      rsp_tmp.status = ffar_pkg::ST_IGNORED;
      row.req = make_free(32'hC000_0000); row.fixed = rsp_tmp; directed_rows.push_back(row);
      rsp_tmp.status = ffar_pkg::ST_OK; rsp_tmp.alloc_addr = 32'hC000_0000;
      row.req = make_alloc(32'd1); row.fixed = rsp_tmp; directed_rows.push_back(row);
      rsp_tmp.alloc_addr = 32'hC000_1000;
      row.req = make_alloc(32'd4096); row.fixed = rsp_tmp; directed_rows.push_back(row);
      rsp_tmp.status = ffar_pkg::ST_NO_RANGE; rsp_tmp.alloc_addr = 0;
      row.req = make_alloc(32'hFFFF_FFFF); row.fixed = rsp_tmp; directed_rows.push_back(row);
      rsp_tmp.status = ffar_pkg::ST_IGNORED;
      row.req = make_free(32'hC000_0001); row.fixed = rsp_tmp; directed_rows.push_back(row);
      row.req = make_free(32'hFFFF_FFFF); row.fixed = rsp_tmp; directed_rows.push_back(row);
      row.req = make_free(32'h0); row.fixed = rsp_tmp; directed_rows.push_back(row);
      rsp_tmp.status = ffar_pkg::ST_OK;
      row.req = make_free(32'hC000_0000); row.fixed = rsp_tmp; directed_rows.push_back(row);
      row.has_fixed = 0;
      row.req = make_alloc(32'd8192); directed_rows.push_back(row);
      row.req = make_alloc(32'd4097); directed_rows.push_back(row);
      row.req = make_alloc(32'h0FFF_F000); directed_rows.push_back(row);
      row.req = make_free(32'hC000_1000); directed_rows.push_back(row);
      row.req = make_alloc(32'd100); directed_rows.push_back(row);
      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].has_fixed,
                      directed_rows[i].fixed);
      drain_responses();

      // fill the table to reach table full
      for (int i = 0; i < MAX_REGIONS + 3; i++)
         send_request(make_alloc($urandom_range(1, 3 * PAGE_BYTES)));

      // receiver holds off while the sender keeps offering
      fork
         begin
            rsp_hold = 1'b1;
            repeat (500) @(posedge clock);
            rsp_hold = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_request(make_free(pick_free_addr()));
      join
      drain_responses();

      // random phases with window changes
      for (int phase = 0; phase < 16; phase++) begin
         win_choice = phase % 8;
         case (win_choice)
            0: begin
               write_window(ffar_pkg::CSR_WINDOW_BASE, 21'd0);
               write_window(ffar_pkg::CSR_WINDOW_END, 21'd1048576);
            end
            1: begin
               write_window(ffar_pkg::CSR_WINDOW_BASE, 21'd1048575);
               write_window(ffar_pkg::CSR_WINDOW_END, 21'd2097151);
            end
            2: begin
               write_window(ffar_pkg::CSR_WINDOW_BASE, 21'd500);
               write_window(ffar_pkg::CSR_WINDOW_END, 21'd100);
            end
            3: begin
               write_window(ffar_pkg::CSR_WINDOW_BASE,
                            ffar_pkg::COUNT_W'(ffar_pkg::WINDOW_BASE_RESET));
               write_window(ffar_pkg::CSR_WINDOW_END, ffar_pkg::WINDOW_END_RESET);
            end
            4: begin
               write_window(ffar_pkg::CSR_WINDOW_BASE, 21'($urandom_range(0, 1048575)));
               write_window(ffar_pkg::CSR_WINDOW_END, 21'($urandom_range(0, 2097151)));
            end
            5: write_window(ffar_pkg::CSR_WINDOW_BASE, 21'($urandom_range(1000, 4000)));
            6: write_window(ffar_pkg::CSR_WINDOW_END, 21'($urandom_range(4000, 6000)));
            default: begin
               write_window(ffar_pkg::CSR_WINDOW_BASE, 21'd1048000);
               write_window(ffar_pkg::CSR_WINDOW_END, 21'd1048576);
            end
         endcase
         idle_enable = (phase != 5);
         for (int i = 0; i < 95; i++) begin
            if ($urandom_range(99) < 55) begin
               case ($urandom_range(9))
                  0: sz = $urandom;
                  1: sz = 0;
                  2: sz = 32'hFFFF_FFFF - $urandom_range(8191);
                  default: sz = $urandom_range(1, 16 * PAGE_BYTES);
               endcase
               send_request(make_alloc(sz));
            end else
               send_request(make_free(pick_free_addr()));
         end
         idle_enable = 1'b1;
         drain_responses();
      end

      if (error_count == 0)
         $display("first_fit_address_range_allocator verification clean");
      else
         $display("first_fit_address_range_allocator verification failed");
      $finish;
   end
endmodule
